// ===== hdl/digest_mismatch_run_extractor_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef DIGEST_MISMATCH_RUN_EXTRACTOR_ASSERT_SVH
`define DIGEST_MISMATCH_RUN_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DMRE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DMRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dmre_pkg.sv =====
package dmre_pkg;

    // Field widths.
    localparam int DIGEST_W   = 64;
    localparam int OFFSET_W   = 48;
    localparam int BYTES_W    = 24;
    localparam int LEN_W      = 15;
    localparam int POS_W      = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BYTES = 2'd1;

    // Queue depths between the parts of the block.
    localparam int MID_DEPTH  = 2;
    localparam int OUT_DEPTH  = 2;

    // Parameter defaults.
    localparam int SEGMENT_BYTES_DEF = 4096;
    localparam int SECTOR_SHIFT_DEF  = 9;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // One classified input beat.
    typedef struct packed {
        logic differ;
        logic last;
    } t_cls;

    // One result beat.
    typedef struct packed {
        logic [OFFSET_W-1:0] run_offset_sectors;
        logic [LEN_W-1:0]    run_length_sectors;
        logic [BYTES_W-1:0]  dirty_bytes_total;
        logic                final_flush;
    } t_run;

endpackage

// ===== hdl/dmre_queue.sv =====
module dmre_queue #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/dmre_front.sv =====
module dmre_front
    import dmre_pkg::*;
(
    input  logic [DIGEST_W-1:0] i_local_digest_hi,
    input  logic [DIGEST_W-1:0] i_local_digest_lo,
    input  logic [DIGEST_W-1:0] i_remote_digest_hi,
    input  logic [DIGEST_W-1:0] i_remote_digest_lo,
    input  logic                i_last_segment,
    output t_cls                o_cls
);

    // A segment is dirty when any bit of the two 128-bit digests differs.
    always_comb begin
        o_cls.differ = (i_local_digest_hi != i_remote_digest_hi) ||
                       (i_local_digest_lo != i_remote_digest_lo);
        o_cls.last   = i_last_segment;
    end

endmodule

// ===== hdl/dmre_back.sv =====
module dmre_back
    import dmre_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF,
    parameter int SECTOR_SHIFT  = SECTOR_SHIFT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_cls                  i_cls,
    output logic                  o_take,
    input  logic                  i_out_full,
    output logic                  o_out_push,
    output t_run                  o_out_data
);

    logic [OFFSET_W-1:0] r_base_offset;
    logic [BYTES_W-1:0]  r_region_bytes;
    logic [BYTES_W-1:0]  r_bytes_remaining, n_bytes_remaining;
    logic [BYTES_W-1:0]  r_run_bytes, n_run_bytes;
    logic [OFFSET_W-1:0] r_run_start, n_run_start;
    logic [POS_W-1:0]    r_segment_byte_pos, n_segment_byte_pos;
    logic [BYTES_W-1:0]  r_dirty_total, n_dirty_total;

    logic [BYTES_W-1:0]  seg;
    logic [BYTES_W-1:0]  run_add;
    logic [BYTES_W-1:0]  emit_bytes;
    logic [BYTES_W-1:0]  dirty_new;
    logic [BYTES_W-1:0]  len_full;
    logic [POS_W-1:0]    end_pos;
    logic                emit_match;
    logic                emit_last;
    logic                emit;
    logic                cfg_hit;

    function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                   input logic [BYTES_W-1:0] b);
        logic [BYTES_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
    endfunction

    assign o_take  = i_valid && !i_out_full;
    assign cfg_hit = i_cfg_we &&
                     ((i_cfg_idx == REG_BASE_OFFSET) || (i_cfg_idx == REG_REGION_BYTES));

    // Segment coverage, run growth and emit decision for the beat at the head.
    always_comb begin
        seg = (r_bytes_remaining < BYTES_W'(SEGMENT_BYTES)) ?
              r_bytes_remaining : BYTES_W'(SEGMENT_BYTES);
        run_add    = sat_add(r_run_bytes, seg);
        emit_match = !i_cls.differ && (r_run_bytes != '0);
        emit_last  = i_cls.last && i_cls.differ && (run_add != '0);
        emit       = emit_match || emit_last;
        emit_bytes = i_cls.differ ? run_add : r_run_bytes;
        dirty_new  = sat_add(r_dirty_total, emit_bytes);
        len_full   = emit_bytes >> SECTOR_SHIFT;
        end_pos    = r_segment_byte_pos + POS_W'(seg);
    end

    // Result beat.
    always_comb begin
        o_out_push                    = o_take && emit;
        o_out_data.run_offset_sectors = r_run_start;
        o_out_data.run_length_sectors = (len_full > BYTES_W'(LEN_MAX)) ?
                                        LEN_MAX : len_full[LEN_W-1:0];
        o_out_data.dirty_bytes_total  = dirty_new;
        o_out_data.final_flush        = emit_last;
    end

    // Next region state.
    always_comb begin
        n_bytes_remaining  = r_bytes_remaining;
        n_run_bytes        = r_run_bytes;
        n_run_start        = r_run_start;
        n_segment_byte_pos = r_segment_byte_pos;
        n_dirty_total      = r_dirty_total;
        if (cfg_hit) begin
            // A register write restarts the region with the new values.
            n_bytes_remaining  = (i_cfg_idx == REG_REGION_BYTES) ?
                                 i_cfg_data[BYTES_W-1:0] : r_region_bytes;
            n_run_start        = (i_cfg_idx == REG_BASE_OFFSET) ?
                                 i_cfg_data[OFFSET_W-1:0] : r_base_offset;
            n_run_bytes        = '0;
            n_segment_byte_pos = '0;
            n_dirty_total      = '0;
        end else if (o_take) begin
            if (i_cls.last) begin
                n_bytes_remaining  = r_region_bytes;
                n_run_start        = r_base_offset;
                n_run_bytes        = '0;
                n_segment_byte_pos = '0;
                n_dirty_total      = '0;
            end else begin
                n_bytes_remaining  = r_bytes_remaining - seg;
                n_segment_byte_pos = r_segment_byte_pos + POS_W'(SEGMENT_BYTES);
                n_run_bytes        = i_cls.differ ? run_add : '0;
                n_dirty_total      = emit ? dirty_new : r_dirty_total;
                if (!i_cls.differ) begin
                    // The next run can start no earlier than past this clean segment.
                    n_run_start = r_base_offset +
                                  OFFSET_W'(end_pos >> SECTOR_SHIFT);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_offset      <= '0;
            r_region_bytes     <= '0;
            r_bytes_remaining  <= '0;
            r_run_bytes        <= '0;
            r_run_start        <= '0;
            r_segment_byte_pos <= '0;
            r_dirty_total      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == REG_BASE_OFFSET)) begin
                r_base_offset <= i_cfg_data[OFFSET_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == REG_REGION_BYTES)) begin
                r_region_bytes <= i_cfg_data[BYTES_W-1:0];
            end
            r_bytes_remaining  <= n_bytes_remaining;
            r_run_bytes        <= n_run_bytes;
            r_run_start        <= n_run_start;
            r_segment_byte_pos <= n_segment_byte_pos;
            r_dirty_total      <= n_dirty_total;
        end
    end

endmodule

// ===== hdl/digest_mismatch_run_extractor.sv =====
// Digest mismatch run extractor.
// Input channel (push/full): one beat per segment, carrying the local and
// remote 128-bit digests and a last-segment flag. A beat is taken when push
// is high and full is low. Output channel (empty/pop): one beat per dirty run
// with its start sector, length in sectors, the running dirty byte total and
// a flag telling whether the end of the region closed it.
// A result caused by a segment is registered in the front queue, then in the
// output queue, before it shows on the output. Throughput is one segment per
// cycle, set by the back end's region update, while the output queue is not
// full. The configuration port writes the region base and length; each write
// restarts the region. The user must issue writes only while the block is idle;
// the block does not enforce this. Reset clears both queues and all region state
// and registers to zero. When pop stays low, the two-entry output queue fills, the
// back end stops, then the two-entry queue in front of it fills and full goes high.
module digest_mismatch_run_extractor
    import dmre_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF,
    parameter int SECTOR_SHIFT  = SECTOR_SHIFT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [DIGEST_W-1:0]   i_local_digest_hi,
    input  logic [DIGEST_W-1:0]   i_local_digest_lo,
    input  logic [DIGEST_W-1:0]   i_remote_digest_hi,
    input  logic [DIGEST_W-1:0]   i_remote_digest_lo,
    input  logic                  i_last_segment,
    output logic                  empty,
    input  logic                  pop,
    output logic [OFFSET_W-1:0]   o_run_offset_sectors,
    output logic [LEN_W-1:0]      o_run_length_sectors,
    output logic [BYTES_W-1:0]    o_dirty_bytes_total,
    output logic                  o_final_flush
);

    t_cls cls_in;
    t_cls cls_head;
    logic mid_empty;
    logic back_take;
    logic out_full;
    logic out_push;
    t_run out_data;
    t_run out_head;

    // Front end: classify each segment beat.
    dmre_front u_front (
        .i_local_digest_hi  (i_local_digest_hi),
        .i_local_digest_lo  (i_local_digest_lo),
        .i_remote_digest_hi (i_remote_digest_hi),
        .i_remote_digest_lo (i_remote_digest_lo),
        .i_last_segment     (i_last_segment),
        .o_cls              (cls_in)
    );

    // Queue between front end and back end.
    dmre_queue #(
        .WIDTH ($bits(t_cls)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .o_full  (full),
        .i_pop   (back_take),
        .o_data  (cls_head),
        .o_empty (mid_empty)
    );

    // Back end: region state and run emission.
    dmre_back #(
        .SEGMENT_BYTES (SEGMENT_BYTES),
        .SECTOR_SHIFT  (SECTOR_SHIFT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (!mid_empty),
        .i_cls      (cls_head),
        .o_take     (back_take),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_data (out_data)
    );

    // Result queue toward the consumer.
    dmre_queue #(
        .WIDTH ($bits(t_run)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_head),
        .o_empty (empty)
    );

    assign o_run_offset_sectors = out_head.run_offset_sectors;
    assign o_run_length_sectors = out_head.run_length_sectors;
    assign o_dirty_bytes_total  = out_head.dirty_bytes_total;
    assign o_final_flush        = out_head.final_flush;

endmodule

// ===== hdl/dmre_checker.sv =====
`include "digest_mismatch_run_extractor_assert.svh"

module dmre_checker
    import dmre_pkg::*;
#(
    parameter int SECTOR_SHIFT = SECTOR_SHIFT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [OFFSET_W-1:0]   o_run_offset_sectors,
    input  logic [LEN_W-1:0]      o_run_length_sectors,
    input  logic [BYTES_W-1:0]    o_dirty_bytes_total,
    input  logic                  o_final_flush
);

    // Nothing is waiting on the output right after reset.
    `DMRE_ASSERT_NOW(a_empty_after_reset, i_clk, i_rst_n, $past(!i_rst_n), empty, "output not empty after reset")

    // A result that is not taken stays on the ports unchanged.
    `DMRE_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_run_offset_sectors) && $stable(o_run_length_sectors) && $stable(o_dirty_bytes_total) && $stable(o_final_flush), "waiting result changed")

    // The input side only fills up after a beat was pushed.
    `DMRE_ASSERT_NOW(a_full_after_push, i_clk, i_rst_n, $rose(full), $past(push), "full rose without a push")

    // The running dirty total always covers the bytes of the run it reports.
    `DMRE_ASSERT_NOW(a_total_covers_run, i_clk, i_rst_n, !empty, (o_dirty_bytes_total >> SECTOR_SHIFT) >= BYTES_W'(o_run_length_sectors), "dirty total below run length")

endmodule

bind digest_mismatch_run_extractor dmre_checker #(
    .SECTOR_SHIFT (SECTOR_SHIFT)
) u_dmre_checker (.*);

// ===== bench/tb.sv =====
module tb;
    import dmre_pkg::*;

    localparam int SEG_BYTES      = SEGMENT_BYTES_DEF;
    localparam int SEC_SHIFT      = SECTOR_SHIFT_DEF;
    localparam int RAND_BEATS     = 1750;
    localparam int MAX_SPAN       = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [DIGEST_W-1:0]   DIG_A  = 64'h0123_4567_89AB_CDEF;
    localparam logic [DIGEST_W-1:0]   DIG_B  = 64'hFEDC_BA98_7654_3210;
    localparam logic [DIGEST_W-1:0]   ONES   = '1;
    localparam logic [DIGEST_W-1:0]   ZEROS  = '0;
    localparam logic [CFG_DATA_W-1:0] MAX48  = '1;

    typedef enum logic {ROW_WRITE, ROW_SEG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [DIGEST_W-1:0]   lhi;
        logic [DIGEST_W-1:0]   llo;
        logic [DIGEST_W-1:0]   rhi;
        logic [DIGEST_W-1:0]   rlo;
        logic                  is_last;
        bit                    typed;
        t_run                  run;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    logic [DIGEST_W-1:0]   i_local_digest_hi;
    logic [DIGEST_W-1:0]   i_local_digest_lo;
    logic [DIGEST_W-1:0]   i_remote_digest_hi;
    logic [DIGEST_W-1:0]   i_remote_digest_lo;
    logic                  i_last_segment;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [OFFSET_W-1:0]   o_run_offset_sectors;
    logic [LEN_W-1:0]      o_run_length_sectors;
    logic [BYTES_W-1:0]    o_dirty_bytes_total;
    logic                  o_final_flush;

    // Region tracker state, mirroring what the block keeps.
    logic [OFFSET_W-1:0] cfg_base;
    logic [BYTES_W-1:0]  cfg_len;
    logic [BYTES_W-1:0]  left_bytes;
    logic [BYTES_W-1:0]  open_bytes;
    logic [OFFSET_W-1:0] open_start;
    logic [POS_W-1:0]    seg_pos;
    logic [BYTES_W-1:0]  dirty_sum;

    t_run      runs_due[$];
    t_stim_row dir_rows[$];

    int  idle_pct      = 11;
    bit  hold_req      = 1'b0;
    bit  rst_released  = 1'b0;
    int  mismatches    = 0;
    int  runs_checked  = 0;
    int  seg_beats     = 0;
    int  reg_writes    = 0;
    int  regions       = 0;

    digest_mismatch_run_extractor #(
        .SEGMENT_BYTES(SEG_BYTES),
        .SECTOR_SHIFT (SEC_SHIFT)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .push                (push),
        .full                (full),
        .i_local_digest_hi   (i_local_digest_hi),
        .i_local_digest_lo   (i_local_digest_lo),
        .i_remote_digest_hi  (i_remote_digest_hi),
        .i_remote_digest_lo  (i_remote_digest_lo),
        .i_last_segment      (i_last_segment),
        .empty               (empty),
        .pop                 (pop),
        .o_run_offset_sectors(o_run_offset_sectors),
        .o_run_length_sectors(o_run_length_sectors),
        .o_dirty_bytes_total (o_dirty_bytes_total),
        .o_final_flush       (o_final_flush)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Saturating add at the byte counter width.
    function automatic logic [BYTES_W-1:0] add_sat24(logic [BYTES_W-1:0] a,
                                                     logic [BYTES_W-1:0] b);
        logic [BYTES_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
    endfunction

    // Start a fresh region from the current register values.
    function automatic void restart_region();
        left_bytes = cfg_len;
        open_start = cfg_base;
        open_bytes = '0;
        seg_pos    = '0;
        dirty_sum  = '0;
    endfunction

    // Close the open run and build its result beat.
    function automatic t_run close_run(logic flush);
        t_run               r;
        logic [BYTES_W-1:0] sectors;
        sectors = open_bytes >> SEC_SHIFT;
        dirty_sum = add_sat24(dirty_sum, open_bytes);
        r.run_offset_sectors = open_start;
        r.run_length_sectors = (sectors > LEN_MAX) ? LEN_MAX : sectors[LEN_W-1:0];
        r.dirty_bytes_total  = dirty_sum;
        r.final_flush        = flush;
        open_bytes = '0;
        return r;
    endfunction

    // Advance the region by one segment; returns 1 when a run closes.
    function automatic bit track_segment(logic differ, logic is_last, output t_run r);
        logic [BYTES_W-1:0] cover_bytes;
        logic [POS_W-1:0]   end_pos;
        bit                 got;
        got = 1'b0;
        r = '0;
        cover_bytes = (left_bytes < SEG_BYTES) ? left_bytes : BYTES_W'(SEG_BYTES);
        if (differ) begin
            open_bytes = add_sat24(open_bytes, cover_bytes);
        end else begin
            if (open_bytes != 0) begin
                r = close_run(1'b0);
                got = 1'b1;
            end
            // The next run can start no earlier than just past this segment.
            end_pos = seg_pos + POS_W'(cover_bytes);
            open_start = cfg_base + OFFSET_W'(end_pos >> SEC_SHIFT);
        end
        left_bytes = left_bytes - cover_bytes;
        seg_pos = seg_pos + POS_W'(SEG_BYTES);
        if (is_last) begin
            if (open_bytes != 0 && !got) begin
                r = close_run(1'b1);
                got = 1'b1;
            end
            restart_region();
        end
        return got;
    endfunction

    function automatic t_stim_row seg_row(logic [DIGEST_W-1:0] lhi, logic [DIGEST_W-1:0] llo,
                                          logic [DIGEST_W-1:0] rhi, logic [DIGEST_W-1:0] rlo,
                                          logic is_last);
        t_stim_row r;
        r.kind    = ROW_SEG;
        r.idx     = '0;
        r.data    = '0;
        r.lhi     = lhi;
        r.llo     = llo;
        r.rhi     = rhi;
        r.rlo     = rlo;
        r.is_last = is_last;
        r.typed   = 1'b0;
        r.run     = '0;
        return r;
    endfunction

    function automatic t_stim_row wr_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = seg_row(ZEROS, ZEROS, ZEROS, ZEROS, 1'b0);
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // Attach a run that can be read straight off the row sequence.
    function automatic t_stim_row with_run(t_stim_row r, logic [OFFSET_W-1:0] offset,
                                           logic [LEN_W-1:0] len,
                                           logic [BYTES_W-1:0] dirty, logic flush);
        r.typed = 1'b1;
        r.run.run_offset_sectors = offset;
        r.run.run_length_sectors = len;
        r.run.dirty_bytes_total  = dirty;
        r.run.final_flush        = flush;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    endtask

    // Stop offering beats and wait until every pending run has come out.
    task automatic drain_results();
        push <= 1'b0;
        while (runs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write, issued only once the block has gone quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_BASE_OFFSET: begin
                cfg_base = data[OFFSET_W-1:0];
                restart_region();
            end
            REG_REGION_BYTES: begin
                cfg_len = data[BYTES_W-1:0];
                restart_region();
            end
            default: ;
        endcase
        reg_writes++;
    endtask

    // Offer one segment beat, hold it until taken, then predict its run.
    task automatic send_segment(input logic [DIGEST_W-1:0] lhi, input logic [DIGEST_W-1:0] llo,
                                input logic [DIGEST_W-1:0] rhi, input logic [DIGEST_W-1:0] rlo,
                                input logic is_last, input bit typed, input t_run typed_run);
        t_run predicted;
        bit   taken;
        bit   has_run;
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push               <= 1'b1;
        i_local_digest_hi  <= lhi;
        i_local_digest_lo  <= llo;
        i_remote_digest_hi <= rhi;
        i_remote_digest_lo <= rlo;
        i_last_segment     <= is_last;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end
        has_run = track_segment((lhi != rhi) || (llo != rlo), is_last, predicted);
        if (has_run)
            runs_due.push_back(typed ? typed_run : predicted);
        seg_beats++;
    endtask

    // Result side: random pop with one long hold-off on request.
    initial begin : sink
        int hold_left;
        bit take;
        hold_left = 0;
        wait (rst_released);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            take = (hold_left == 0) && ($urandom_range(99) >= idle_pct);
            if (hold_left != 0) hold_left--;
            @(posedge i_clk);
            pop <= take;
        end
    end

    // Compare each run beat taken from the block with the oldest prediction.
    always @(negedge i_clk) begin : check_runs
        t_run want;
        if (i_rst_n && pop && !empty) begin
            if (runs_due.size() == 0) begin
                report_mismatch("run beat with none pending, offset",
                                64'(o_run_offset_sectors), '0);
            end else begin
                want = runs_due.pop_front();
                runs_checked++;
                if (o_run_offset_sectors !== want.run_offset_sectors)
                    report_mismatch("run_offset_sectors", 64'(o_run_offset_sectors),
                                    64'(want.run_offset_sectors));
                if (o_run_length_sectors !== want.run_length_sectors)
                    report_mismatch("run_length_sectors", 64'(o_run_length_sectors),
                                    64'(want.run_length_sectors));
                if (o_dirty_bytes_total !== want.dirty_bytes_total)
                    report_mismatch("dirty_bytes_total", 64'(o_dirty_bytes_total),
                                    64'(want.dirty_bytes_total));
                if (o_final_flush !== want.final_flush)
                    report_mismatch("final_flush", 64'(o_final_flush),
                                    64'(want.final_flush));
            end
        end
    end

    // End the run when no beat moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] data;
        logic [DIGEST_W-1:0]   lhi, llo, rhi, rlo;
        int                    span, count, shape, pick, first_rand;
        bit                    dirty, mark_last, hold_done;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        push               = 1'b0;
        i_local_digest_hi  = '0;
        i_local_digest_lo  = '0;
        i_remote_digest_hi = '0;
        i_remote_digest_lo = '0;
        i_last_segment     = 1'b0;
        cfg_base           = '0;
        cfg_len            = '0;
        restart_region();
        hold_done          = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_released = 1'b1;

        // Directed rows: empty region after reset, wrap of the run start,
        // a partial last segment, segments past the region, a match on the
        // last segment, ignored indexes and a write that abandons a region.
        dir_rows = '{
            seg_row(ZEROS, ZEROS, ZEROS, ZEROS, 1'b0),
            seg_row(ONES, ONES, ZEROS, ZEROS, 1'b0),
            seg_row(ONES, ZEROS, ONES, ZEROS, 1'b1),
            wr_row(REG_BASE_OFFSET, MAX48),
            wr_row(REG_REGION_BYTES, MAX48),
            seg_row(DIG_A, DIG_B, ~DIG_A, DIG_B, 1'b0),
            seg_row(DIG_A, DIG_B, DIG_A, ~DIG_B, 1'b0),
            with_run(seg_row(ONES, ONES, ONES, ONES, 1'b0), MAX48, 15'd16, 24'd8192, 1'b0),
            with_run(seg_row(DIG_A, DIG_A, DIG_B, DIG_B, 1'b1), 48'd23, 15'd8, 24'd12288, 1'b1),
            wr_row(REG_BASE_OFFSET, '0),
            wr_row(REG_REGION_BYTES, 48'd5000),
            seg_row(ZEROS, ZEROS, ZEROS, 64'd1, 1'b0),
            seg_row(64'h8000_0000_0000_0000, ZEROS, ZEROS, ZEROS, 1'b0),
            with_run(seg_row(DIG_B, DIG_A, DIG_B, DIG_A, 1'b0), 48'd0, 15'd9, 24'd5000, 1'b0),
            seg_row(ONES, ONES, ONES, ZEROS, 1'b0),
            seg_row(DIG_A, DIG_A, DIG_A, DIG_A, 1'b1),
            wr_row(REG_BASE_OFFSET, 48'd100),
            seg_row(DIG_A, ONES, DIG_B, ONES, 1'b0),
            with_run(seg_row(DIG_B, DIG_B, DIG_B, DIG_B, 1'b1), 48'd100, 15'd8, 24'd4096, 1'b0),
            seg_row(ZEROS, ONES, ONES, ONES, 1'b0),
            wr_row(REG_SPARE_2, MAX48),
            seg_row(ONES, ZEROS, ZEROS, ZEROS, 1'b0),
            wr_row(REG_SPARE_3, '0),
            with_run(seg_row(ONES, DIG_A, ONES, DIG_A, 1'b0), 48'd100, 15'd9, 24'd5000, 1'b0),
            seg_row(DIG_A, DIG_B, DIG_B, DIG_A, 1'b0),
            wr_row(REG_REGION_BYTES, 48'd8192),
            with_run(seg_row(ZEROS, ZEROS, ONES, ONES, 1'b1), 48'd100, 15'd8, 24'd4096, 1'b1)
        };

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                send_segment(dir_rows[i].lhi, dir_rows[i].llo, dir_rows[i].rhi,
                             dir_rows[i].rlo, dir_rows[i].is_last, dir_rows[i].typed,
                             dir_rows[i].run);
        end

        // Random regions, mostly well formed with random digests.
        first_rand = seg_beats;
        while (seg_beats - first_rand < RAND_BEATS) begin
            // One long output stall while beats keep coming in.
            if (!hold_done && seg_beats - first_rand > 500) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            idle_pct = (seg_beats - first_rand > 900 && seg_beats - first_rand < 1200) ? 0 : 11;

            // New register values now and then; otherwise the region reloads.
            if ($urandom_range(2) == 0) begin
                pick = $urandom_range(9);
                if (pick != 0) begin
                    case ($urandom_range(4))
                        0:       data = '0;
                        1:       data = MAX48;
                        2:       data = 48'hFFFF_FFFF_FF00;
                        default: data = CFG_DATA_W'({$urandom, $urandom});
                    endcase
                    write_reg(REG_BASE_OFFSET, data);
                end
                if (pick != 1) begin
                    case ($urandom_range(9))
                        0:       data = '0;
                        1:       data = 48'hFF_FFFF;
                        2:       data = CFG_DATA_W'({$urandom, $urandom});
                        3:       data = CFG_DATA_W'(SEG_BYTES * $urandom_range(1, MAX_SPAN));
                        default: data = CFG_DATA_W'($urandom_range(1, MAX_SPAN * SEG_BYTES));
                    endcase
                    write_reg(REG_REGION_BYTES, data);
                end
                if (pick == 2)
                    write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                              CFG_DATA_W'({$urandom, $urandom}));
            end else if ($urandom_range(7) == 0) begin
                drain_results();
            end

            span = (int'(cfg_len) + SEG_BYTES - 1) / SEG_BYTES;
            if (span == 0)
                span = $urandom_range(1, 3);
            if (span > MAX_SPAN)
                span = $urandom_range(1, MAX_SPAN);

            // Mostly whole regions; a few run past the end, stop early or
            // never mark the last segment.
            shape = $urandom_range(19);
            count = span;
            if (shape < 2)
                count = span + $urandom_range(1, 3);
            else if (shape < 4)
                count = $urandom_range(1, span);
            mark_last = (shape != 4);

            dirty = $urandom_range(1);
            for (int k = 1; k <= count; k++) begin
                if ($urandom_range(9) < 3)
                    dirty = !dirty;
                lhi = {$urandom, $urandom};
                llo = {$urandom, $urandom};
                rhi = lhi;
                rlo = llo;
                if (dirty) begin
                    case ($urandom_range(3))
                        0: rhi = ~lhi;
                        1: rlo = ~llo;
                        2: begin
                            rhi = {$urandom, $urandom};
                            rlo = {$urandom, $urandom};
                        end
                        default: begin
                            if ($urandom_range(1))
                                rhi = rhi ^ (64'd1 << $urandom_range(63));
                            else
                                rlo = rlo ^ (64'd1 << $urandom_range(63));
                        end
                    endcase
                end
                send_segment(lhi, llo, rhi, rlo, mark_last && (k == count), 1'b0, '0);
            end
            regions++;
        end

        drain_results();
        $display("Run covered %0d segment beats (%0d random regions), %0d runs compared.",
                 seg_beats, regions, runs_checked);
        $display("%0d register writes, a %0d-cycle output stall and a stretch without idling.",
                 reg_writes, HOLD_CYCLES);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
